@@ rtl/core/bpa_pkg.sv @@
// Shared types and constants for the buddy page allocator.
// Holds the page entry layout, the state machine encoding and the request codes.
// No dependencies.
package bpa_pkg;

   // Pool geometry
   localparam int PAGE_CAPACITY = 4096;
   localparam int ORDER_COUNT   = 9;
   localparam int PAGE_SHIFT    = 12;

   localparam int ADDR_W   = 32;
   localparam int PAGE_W   = $clog2(PAGE_CAPACITY);
   localparam int LINK_W   = PAGE_W + 1;
   localparam int ORD_W    = $clog2(ORDER_COUNT + 1);
   localparam int LIST_W   = $clog2(ORDER_COUNT);
   localparam int PAGES_W  = ADDR_W + 1 - PAGE_SHIFT;
   localparam int IDX_W    = ADDR_W - PAGE_SHIFT;
   localparam int ALIGN_W  = PAGE_SHIFT + 2;

   localparam logic [LINK_W-1:0] NO_LINK   = LINK_W'(PAGE_CAPACITY);
   localparam logic [ORD_W-1:0]  ORD_NONE  = ORD_W'(ORDER_COUNT);
   localparam logic [ORD_W-1:0]  TOP_ORDER = ORD_W'(ORDER_COUNT - 1);
   localparam logic [ADDR_W:0]   ALIGN_MASK = (ADDR_W + 1)'((64'd1 << ALIGN_W) - 64'd1);
   localparam logic [ADDR_W:0]   PAGE_MASK  = (ADDR_W + 1)'((64'd1 << PAGE_SHIFT) - 64'd1);
   localparam logic [PAGES_W-1:0] MAX_REQ_PAGES = PAGES_W'(64'd1 << (ORDER_COUNT - 1));

   // Configuration port
   localparam int CSR_ADDR_W = 3;
   localparam logic CSR_POOL_START = 1'b0;
   localparam logic CSR_POOL_END   = 1'b1;
   localparam logic [ADDR_W-1:0] POOL_END_RESET = 32'h0100_0000;

   typedef enum logic [1:0] {
      MODE_ALLOC   = 2'd0,
      MODE_FREE    = 2'd1,
      MODE_REBUILD = 2'd2,
      MODE_NOP     = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      STATUS_OK         = 3'd0,
      STATUS_NO_SPACE   = 3'd1,
      STATUS_UNALIGNED  = 3'd2,
      STATUS_BELOW_POOL = 3'd3,
      STATUS_BEYOND_END = 3'd4
   } status_type;

   // One page entry in the page memory.
   typedef struct packed {
      logic [ORD_W-1:0]  order;
      logic              free_head;
      logic [LINK_W-1:0] next_link;
      logic [LINK_W-1:0] prev_link;
   } page_entry_type;

   localparam int ENTRY_W = $bits(page_entry_type);

   // Pool bounds as programmed, base already aligned.
   typedef struct packed {
      logic [ADDR_W:0]   base;
      logic [ADDR_W-1:0] limit;
   } pool_geom_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_RB_START,
      ST_CLEAR,
      ST_RB_NEXT,
      ST_REL_START,
      ST_REL_CHK,
      ST_REL_MATE,
      ST_UL_PR,
      ST_UL_PRW,
      ST_UL_NX,
      ST_UL_NXW,
      ST_PUSH,
      ST_PUSH_OH,
      ST_ALLOC,
      ST_ALLOC_FIND,
      ST_ALLOC_RD,
      ST_SPLIT,
      ST_FREE_CHK,
      ST_FREE_IDX,
      ST_FINISH
   } state_type;

endpackage

@@ rtl/core/bpa_ram.sv @@
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module bpa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Read returns the old contents when both ports hit the same entry.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

@@ rtl/core/bpa_csr.sv @@
// Configuration registers of the buddy page allocator and the aligned pool base.
// Depends on bpa_pkg.
module bpa_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [bpa_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [bpa_pkg::ADDR_W-1:0]        pwdata,
   output logic [bpa_pkg::ADDR_W-1:0]        prdata,
   output logic                              pready,
   output bpa_pkg::pool_geom_type            geom
);
   import bpa_pkg::*;

   logic [ADDR_W-1:0] pool_start_ff, pool_start_in;
   logic [ADDR_W-1:0] pool_end_ff, pool_end_in;
   logic              wr_strobe;
   logic [ADDR_W:0]   start_round;

   assign pready    = 1'b1;
   assign wr_strobe = psel & penable & pwrite;

   // Register write decode.
   always_comb begin
      pool_start_in = pool_start_ff;
      pool_end_in   = pool_end_ff;
      if (wr_strobe) begin
         unique case (paddr[2])
            CSR_POOL_START: pool_start_in = pwdata;
            CSR_POOL_END:   pool_end_in   = pwdata;
            default: ;
         endcase
      end
   end

   // Read mux.
   always_comb begin
      unique case (paddr[2])
         CSR_POOL_START: prdata = pool_start_ff;
         CSR_POOL_END:   prdata = pool_end_ff;
         default:        prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pool_start_ff <= '0;
         pool_end_ff   <= POOL_END_RESET;
      end else begin
         pool_start_ff <= pool_start_in;
         pool_end_ff   <= pool_end_in;
      end
   end

   // The base is rounded up to a four page boundary and may carry into bit 32.
   assign start_round = {1'b0, pool_start_ff} + ALIGN_MASK;
   assign geom.base   = start_round & ~ALIGN_MASK;
   assign geom.limit  = pool_end_ff;

endmodule

@@ rtl/core/buddy_page_allocator_unit.sv @@
// Buddy page allocator top level: request sequencer around the page memory.
// Depends on bpa_pkg, bpa_ram and bpa_csr.
//
// The allocator keeps one LIFO free list per block order over a pool of up to 4096 pages.
// Page order, free flag and both list links live in one page memory with a registered read,
// and every list edit is a read, modify and write of that memory.
// Requests are handled one at a time. An allocate takes longer with each split and a free
// with each buddy merge. A rebuild, and the one that runs after reset, clears the page
// memory and then frees every pool page in turn, during which no request is accepted.
// Configuration writes are taken at any time and apply at the next rebuild. One response
// is returned per request; a finished response waits in an output register while the next
// request is already being worked on.
module buddy_page_allocator_unit (
   input  logic                           clock,
   input  logic                           reset,
   // Request channel
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [1:0]                     req_mode,
   input  logic [bpa_pkg::ADDR_W-1:0]     req_request_bytes,
   input  logic [bpa_pkg::ADDR_W-1:0]     req_release_address,
   // Response channel
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [bpa_pkg::ADDR_W-1:0]     rsp_block_address,
   output logic [2:0]                     rsp_status,
   // Configuration port
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [bpa_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [bpa_pkg::ADDR_W-1:0]     pwdata,
   output logic [bpa_pkg::ADDR_W-1:0]     prdata,
   output logic                           pready
);
   import bpa_pkg::*;

   // Control state
   state_type         state_ff, state_in;
   mode_type          op_ff, op_in;
   logic              report_ff, report_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // Working registers
   logic [ADDR_W-1:0] opnd_ff, opnd_in;
   logic [ORD_W-1:0]  want_ff, want_in;
   logic [ORD_W-1:0]  k_ff, k_in;
   logic [PAGE_W-1:0] p_ff, p_in;
   logic [ORD_W-1:0]  ul_k_ff, ul_k_in;
   logic [LINK_W-1:0] ul_pr_ff, ul_pr_in;
   logic [LINK_W-1:0] ul_nx_ff, ul_nx_in;
   logic [ORD_W-1:0]  pk_ff, pk_in;
   logic [PAGE_W-1:0] pp_ff, pp_in;
   logic [PAGE_W-1:0] oh_ff, oh_in;
   logic [PAGE_W-1:0] clr_ff, clr_in;
   logic [LINK_W-1:0] rb_ff, rb_in;
   logic [ADDR_W:0]   base_ff, base_in;
   logic [ADDR_W-1:0] end_ff, end_in;
   logic [LINK_W-1:0] usable_ff, usable_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic [LINK_W-1:0] head_ff [ORDER_COUNT];
   logic [LINK_W-1:0] head_in [ORDER_COUNT];
   logic [LINK_W-1:0] cnt_ff [ORDER_COUNT];
   logic [LINK_W-1:0] cnt_in [ORDER_COUNT];
   logic [ADDR_W-1:0] res_addr_ff, res_addr_in;
   status_type        res_status_ff, res_status_in;
   logic [ADDR_W-1:0] rsp_addr_ff, rsp_addr_in;
   status_type        rsp_status_ff, rsp_status_in;

   // Page memory ports
   logic               ram_we;
   logic [PAGE_W-1:0]  ram_waddr;
   page_entry_type     ram_wdata;
   logic [PAGE_W-1:0]  ram_raddr;
   logic [ENTRY_W-1:0] ram_rdata;
   page_entry_type     rd;

   // Helpers
   pool_geom_type      geom;
   logic [LIST_W-1:0]  lsel;
   logic [LINK_W-1:0]  lhead;
   logic [LINK_W-1:0]  lcnt;
   logic [PAGE_W-1:0]  bit_mask;
   logic [PAGE_W-1:0]  mate;
   logic               merge_ok;
   logic               mate_hit;
   logic [ORD_W-1:0]   split_order;
   logic [LINK_W-1:0]  half;
   logic [ADDR_W:0]    page_sum;
   logic [PAGES_W-1:0] pages;
   logic [PAGES_W-1:0] pages_m1;
   logic               too_big;
   logic [ORD_W-1:0]   want_calc;
   logic [LIST_W-1:0]  found;
   logic               found_ok;
   logic [ADDR_W:0]    span;
   logic [PAGES_W-1:0] span_pages;
   logic [LINK_W-1:0]  usable_calc;
   logic               unaligned;
   logic               below;
   logic               beyond;
   logic [ADDR_W-1:0]  diff;
   logic [ADDR_W:0]    block_sum;
   logic               can_load;
   logic               push_link;
   state_type          push_ret;
   state_type          ul_ret;

   bpa_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .geom    (geom)
   );

   bpa_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (PAGE_CAPACITY)
   ) u_page_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign rd = page_entry_type'(ram_rdata);

   // Muxed read of one per order list for unlink, allocate and push; the search reads every list.
   always_comb begin
      unique case (state_ff)
         ST_UL_PR:      lsel = LIST_W'(ul_k_ff);
         ST_ALLOC_FIND: lsel = found;
         default:       lsel = LIST_W'(pk_ff);
      endcase
   end
   assign lhead     = head_ff[lsel];
   assign lcnt      = cnt_ff[lsel];
   assign push_link = (lcnt != '0) && (lhead < NO_LINK);

   // Buddy of the current block and whether a merge is worth looking at.
   assign bit_mask = PAGE_W'(1) << k_ff;
   assign mate     = p_ff ^ bit_mask;
   assign merge_ok = (k_ff < TOP_ORDER) && ({1'b0, mate} < usable_ff);
   assign mate_hit = rd.free_head && (rd.order == k_ff);

   // Upper half of a block being split.
   assign split_order = k_ff - ORD_W'(1);
   assign half        = {1'b0, p_ff} + (LINK_W'(1) << split_order);

   // Request size in pages and the order that covers it.
   assign page_sum = {1'b0, opnd_ff} + PAGE_MASK;
   assign pages    = page_sum[ADDR_W:PAGE_SHIFT];
   assign pages_m1 = pages - PAGES_W'(1);
   assign too_big  = pages > MAX_REQ_PAGES;
   always_comb begin
      want_calc = '0;
      if (pages > PAGES_W'(1)) begin
         for (int i = 0; i < ORDER_COUNT - 1; i++) begin
            if (pages_m1[i]) begin
               want_calc = ORD_W'(i + 1);
            end
         end
      end
   end

   // Lowest non-empty list at or above the wanted order.
   always_comb begin
      found    = '0;
      found_ok = 1'b0;
      for (int i = ORDER_COUNT - 1; i >= 0; i--) begin
         if ((ORD_W'(i) >= want_ff) && (cnt_ff[i] != '0) && (head_ff[i] < NO_LINK)) begin
            found    = LIST_W'(i);
            found_ok = 1'b1;
         end
      end
   end

   // Pool size in pages, saturated at the page capacity.
   assign span       = {1'b0, end_ff} - base_ff;
   assign span_pages = span[ADDR_W:PAGE_SHIFT];
   always_comb begin
      if (base_ff >= {1'b0, end_ff}) begin
         usable_calc = '0;
      end else if (span_pages > PAGES_W'(PAGE_CAPACITY)) begin
         usable_calc = NO_LINK;
      end else begin
         usable_calc = LINK_W'(span_pages);
      end
   end

   // Release address checks.
   assign unaligned = |opnd_ff[PAGE_SHIFT-1:0];
   assign below     = {1'b0, opnd_ff} < base_ff;
   assign beyond    = opnd_ff >= end_ff;
   assign diff      = opnd_ff - base_ff[ADDR_W-1:0];
   assign block_sum = base_ff + (ADDR_W + 1)'({p_ff, {PAGE_SHIFT{1'b0}}});

   // Where a push or an unlink goes back to.
   always_comb begin
      unique case (op_ff)
         MODE_ALLOC:   push_ret = ST_SPLIT;
         MODE_REBUILD: push_ret = ST_RB_NEXT;
         default:      push_ret = ST_FINISH;
      endcase
      ul_ret = (op_ff == MODE_ALLOC) ? ST_SPLIT : ST_REL_CHK;
   end

   assign can_load = !rsp_valid_ff || !rsp_stall;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               unique case (mode_type'(req_mode))
                  MODE_ALLOC:   state_in = ST_ALLOC;
                  MODE_FREE:    state_in = ST_FREE_CHK;
                  MODE_REBUILD: state_in = ST_RB_START;
                  MODE_NOP:     state_in = ST_FINISH;
                  default:      state_in = ST_FINISH;
               endcase
            end
         end
         ST_RB_START: state_in = ST_CLEAR;
         ST_CLEAR: begin
            if (&clr_ff) state_in = ST_RB_NEXT;
         end
         ST_RB_NEXT: begin
            if (rb_ff < usable_ff) state_in = ST_REL_START;
            else                   state_in = report_ff ? ST_FINISH : ST_IDLE;
         end
         ST_REL_START: state_in = rd.free_head ? push_ret : ST_REL_CHK;
         ST_REL_CHK:   state_in = merge_ok ? ST_REL_MATE : ST_PUSH;
         ST_REL_MATE:  state_in = mate_hit ? ST_UL_PR : ST_PUSH;
         ST_UL_PR:     state_in = (ul_pr_ff < NO_LINK) ? ST_UL_PRW : ST_UL_NX;
         ST_UL_PRW:    state_in = ST_UL_NX;
         ST_UL_NX:     state_in = (ul_nx_ff < NO_LINK) ? ST_UL_NXW : ul_ret;
         ST_UL_NXW:    state_in = ul_ret;
         ST_PUSH:      state_in = push_link ? ST_PUSH_OH : push_ret;
         ST_PUSH_OH:   state_in = push_ret;
         ST_ALLOC:     state_in = too_big ? ST_FINISH : ST_ALLOC_FIND;
         ST_ALLOC_FIND: state_in = found_ok ? ST_ALLOC_RD : ST_FINISH;
         ST_ALLOC_RD:  state_in = ST_UL_PR;
         ST_SPLIT: begin
            if (k_ff > want_ff) state_in = (half < NO_LINK) ? ST_PUSH : ST_SPLIT;
            else                state_in = ST_FINISH;
         end
         ST_FREE_CHK:  state_in = (unaligned || below || beyond) ? ST_FINISH : ST_FREE_IDX;
         ST_FREE_IDX: begin
            if ((ADDR_W + 1)'(idx_ff) >= (ADDR_W + 1)'(usable_ff)) state_in = ST_FINISH;
            else                                                   state_in = ST_REL_START;
         end
         ST_FINISH: begin
            if (can_load) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Datapath controls and register updates per state.
   always_comb begin
      op_in         = op_ff;
      report_in     = report_ff;
      opnd_in       = opnd_ff;
      want_in       = want_ff;
      k_in          = k_ff;
      p_in          = p_ff;
      ul_k_in       = ul_k_ff;
      ul_pr_in      = ul_pr_ff;
      ul_nx_in      = ul_nx_ff;
      pk_in         = pk_ff;
      pp_in         = pp_ff;
      oh_in         = oh_ff;
      clr_in        = clr_ff;
      rb_in         = rb_ff;
      base_in       = base_ff;
      end_in        = end_ff;
      usable_in     = usable_ff;
      idx_in        = idx_ff;
      head_in       = head_ff;
      cnt_in        = cnt_ff;
      res_addr_in   = res_addr_ff;
      res_status_in = res_status_ff;
      ram_we        = 1'b0;
      ram_waddr     = p_ff;
      ram_wdata     = rd;
      ram_raddr     = p_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               op_in         = mode_type'(req_mode);
               report_in     = 1'b1;
               opnd_in       = (mode_type'(req_mode) == MODE_FREE) ? req_release_address
                                                                   : req_request_bytes;
               res_addr_in   = '0;
               res_status_in = STATUS_OK;
            end
         end
         ST_RB_START: begin
            base_in = geom.base;
            end_in  = geom.limit;
            clr_in  = '0;
            rb_in   = '0;
            for (int i = 0; i < ORDER_COUNT; i++) begin
               head_in[i] = NO_LINK;
               cnt_in[i]  = '0;
            end
         end
         ST_CLEAR: begin
            ram_we              = 1'b1;
            ram_waddr           = clr_ff;
            ram_wdata.order     = ORD_NONE;
            ram_wdata.free_head = 1'b0;
            ram_wdata.next_link = NO_LINK;
            ram_wdata.prev_link = NO_LINK;
            clr_in              = clr_ff + PAGE_W'(1);
            usable_in           = usable_calc;
         end
         ST_RB_NEXT: begin
            if (rb_ff < usable_ff) begin
               p_in      = rb_ff[PAGE_W-1:0];
               ram_raddr = rb_ff[PAGE_W-1:0];
               rb_in     = rb_ff + LINK_W'(1);
            end
         end
         ST_REL_START: begin
            // A page with no valid order is released as a single page.
            if (!rd.free_head) begin
               k_in = (rd.order >= ORD_NONE) ? '0 : rd.order;
            end
         end
         ST_REL_CHK: begin
            ram_raddr = mate;
            pk_in     = k_ff;
            pp_in     = p_ff;
         end
         ST_REL_MATE: begin
            if (mate_hit) begin
               ram_we              = 1'b1;
               ram_waddr           = mate;
               ram_wdata.order     = ORD_NONE;
               ram_wdata.free_head = 1'b0;
               ul_k_in             = k_ff;
               ul_pr_in            = rd.prev_link;
               ul_nx_in            = rd.next_link;
               p_in                = p_ff & ~bit_mask;
               k_in                = k_ff + ORD_W'(1);
            end
         end
         ST_UL_PR: begin
            ram_raddr = ul_pr_ff[PAGE_W-1:0];
            if (ul_pr_ff >= NO_LINK) begin
               head_in[lsel] = ul_nx_ff;
            end
            if (lcnt != '0) begin
               cnt_in[lsel] = lcnt - LINK_W'(1);
            end
         end
         ST_UL_PRW: begin
            ram_we              = 1'b1;
            ram_waddr           = ul_pr_ff[PAGE_W-1:0];
            ram_wdata.next_link = ul_nx_ff;
         end
         ST_UL_NX: begin
            ram_raddr = ul_nx_ff[PAGE_W-1:0];
         end
         ST_UL_NXW: begin
            ram_we              = 1'b1;
            ram_waddr           = ul_nx_ff[PAGE_W-1:0];
            ram_wdata.prev_link = ul_pr_ff;
         end
         ST_PUSH: begin
            ram_we              = 1'b1;
            ram_waddr           = pp_ff;
            ram_wdata.order     = pk_ff;
            ram_wdata.free_head = 1'b1;
            ram_wdata.next_link = (lcnt != '0) ? lhead : NO_LINK;
            ram_wdata.prev_link = NO_LINK;
            ram_raddr           = lhead[PAGE_W-1:0];
            oh_in               = lhead[PAGE_W-1:0];
            head_in[lsel]       = {1'b0, pp_ff};
            cnt_in[lsel]        = lcnt + LINK_W'(1);
         end
         ST_PUSH_OH: begin
            ram_we              = 1'b1;
            ram_waddr           = oh_ff;
            ram_wdata.prev_link = {1'b0, pp_ff};
         end
         ST_ALLOC: begin
            want_in = want_calc;
            if (too_big) res_status_in = STATUS_NO_SPACE;
         end
         ST_ALLOC_FIND: begin
            if (found_ok) begin
               k_in      = ORD_W'(found);
               p_in      = lhead[PAGE_W-1:0];
               ram_raddr = lhead[PAGE_W-1:0];
            end else begin
               res_status_in = STATUS_NO_SPACE;
            end
         end
         ST_ALLOC_RD: begin
            // The taken block leaves its list and carries the requested order.
            ram_we              = 1'b1;
            ram_waddr           = p_ff;
            ram_wdata.order     = want_ff;
            ram_wdata.free_head = 1'b0;
            ul_k_in             = k_ff;
            ul_pr_in            = rd.prev_link;
            ul_nx_in            = rd.next_link;
         end
         ST_SPLIT: begin
            if (k_ff > want_ff) begin
               k_in  = split_order;
               pk_in = split_order;
               pp_in = half[PAGE_W-1:0];
            end else begin
               res_addr_in = block_sum[ADDR_W-1:0];
            end
         end
         ST_FREE_CHK: begin
            idx_in = diff[ADDR_W-1:PAGE_SHIFT];
            if (unaligned)   res_status_in = STATUS_UNALIGNED;
            else if (below)  res_status_in = STATUS_BELOW_POOL;
            else if (beyond) res_status_in = STATUS_BEYOND_END;
         end
         ST_FREE_IDX: begin
            if ((ADDR_W + 1)'(idx_ff) >= (ADDR_W + 1)'(usable_ff)) begin
               res_status_in = STATUS_BEYOND_END;
            end else begin
               p_in      = idx_ff[PAGE_W-1:0];
               ram_raddr = idx_ff[PAGE_W-1:0];
            end
         end
         ST_FINISH: ;
         default: ;
      endcase
   end

   // Output register: loads when the finished request can be handed over.
   always_comb begin
      rsp_valid_in  = rsp_valid_ff & rsp_stall;
      rsp_addr_in   = rsp_addr_ff;
      rsp_status_in = rsp_status_ff;
      if ((state_ff == ST_FINISH) && can_load) begin
         rsp_valid_in  = 1'b1;
         rsp_addr_in   = res_addr_ff;
         rsp_status_in = res_status_ff;
      end
   end

   // Control registers; reset starts a rebuild from the reset register values.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_RB_START;
         op_ff        <= MODE_REBUILD;
         report_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         op_ff        <= op_in;
         report_ff    <= report_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload and working registers.
   always_ff @(posedge clock) begin
      opnd_ff       <= opnd_in;
      want_ff       <= want_in;
      k_ff          <= k_in;
      p_ff          <= p_in;
      ul_k_ff       <= ul_k_in;
      ul_pr_ff      <= ul_pr_in;
      ul_nx_ff      <= ul_nx_in;
      pk_ff         <= pk_in;
      pp_ff         <= pp_in;
      oh_ff         <= oh_in;
      clr_ff        <= clr_in;
      rb_ff         <= rb_in;
      base_ff       <= base_in;
      end_ff        <= end_in;
      usable_ff     <= usable_in;
      idx_ff        <= idx_in;
      head_ff       <= head_in;
      cnt_ff        <= cnt_in;
      res_addr_ff   <= res_addr_in;
      res_status_ff <= res_status_in;
      rsp_addr_ff   <= rsp_addr_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign req_stall         = (state_ff != ST_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_block_address = rsp_addr_ff;
   assign rsp_status        = rsp_status_ff;

   // The page memory is never written while waiting for a request.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !ram_we)
      else $error("page memory written while idle");

   // A response only appears out of the finish step.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_FINISH))
      else $error("response raised outside the finish step");

   // Splitting never goes below the requested order.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SPLIT) |-> (k_ff >= want_ff))
      else $error("split order below requested order");

endmodule
